// ===== rtl/core/ccvp_pkg.sv =====
`default_nettype none

package ccvp_pkg;

	// Kind of color value being parsed.
	typedef enum logic [1:0] {
		FORM_UNDECIDED = 2'd0,
		FORM_RGB       = 2'd1,
		FORM_RGBA      = 2'd2,
		FORM_HEX       = 2'd3
	} form_t;

	// Character codes of the recognized prefixes, digits and letters.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PAREN = 8'h28;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5a;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_B  = 8'h62;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_LO_G  = 8'h67;
	localparam logic [7:0] CH_LO_R  = 8'h72;

	// Hex digit counts that form a valid value, and the saturation count.
	localparam logic [3:0] HEX_SHORT   = 4'd3;
	localparam logic [3:0] HEX_SHORT_A = 4'd4;
	localparam logic [3:0] HEX_LONG    = 4'd6;
	localparam logic [3:0] HEX_LONG_A  = 4'd8;
	localparam logic [3:0] HEX_OVER    = 4'd9;

	// Number of decimal components kept.
	localparam logic [2:0] NUM_COMP = 3'd4;

	// Status codes.
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	// One character as it enters the parser.
	typedef struct packed {
		logic       valid;
		logic [7:0] char_code;
		logic       last_char;
	} step_t;

	// One parsed color.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       status;
	} color_t;

endpackage

`default_nettype wire

// ===== rtl/core/ccvp_parser.sv =====
`default_nettype none

module ccvp_parser
	import ccvp_pkg::*;
(
	input  wire    clk,
	input  wire    arst_n,
	input  step_t  step,
	output color_t color
);

	// Parser state.
	form_t       form_q;
	logic [2:0]  prefix_pos_q;
	logic [3:0]  hex_cnt_q;
	logic [31:0] nibbles_q;
	logic [7:0]  acc_q;
	logic [2:0]  comp_idx_q;
	logic        in_run_q;
	logic [7:0]  store_q [4];
	logic        failed_q;

	// Values after the current character is taken.
	form_t       form_d;
	logic [2:0]  prefix_pos_d;
	logic [3:0]  hex_cnt_d;
	logic [31:0] nibbles_d;
	logic [7:0]  acc_d;
	logic [2:0]  comp_idx_d;
	logic        in_run_d;
	logic [7:0]  store_d [4];
	logic        failed_d;

	// Character classification.
	logic [7:0]  ch;
	logic [7:0]  lc;
	logic        is_digit;
	logic        is_hex_letter;
	logic [3:0]  hex_val;
	logic [11:0] dec_sum;

	assign ch            = step.char_code;
	assign lc            = (ch >= CH_UP_A && ch <= CH_UP_Z) ? (ch | 8'h20) : ch;
	assign is_digit      = (ch >= CH_ZERO && ch <= CH_NINE);
	assign is_hex_letter = (lc >= CH_LO_A && lc <= CH_LO_F);
	assign hex_val       = is_digit ? ch[3:0] : (lc[3:0] + 4'd9);
	assign dec_sum       = ({4'd0, acc_q} * 12'd10) + {8'd0, ch[3:0]};

	// Next-state logic for one character.
	always_comb begin
		form_d       = form_q;
		prefix_pos_d = prefix_pos_q;
		hex_cnt_d    = hex_cnt_q;
		nibbles_d    = nibbles_q;
		acc_d        = acc_q;
		comp_idx_d   = comp_idx_q;
		in_run_d     = in_run_q;
		store_d      = store_q;
		failed_d     = failed_q;
		if (!failed_q) begin
			case (form_q)
				FORM_UNDECIDED: begin
					case (prefix_pos_q)
						3'd0: begin
							if (ch == CH_SPACE) begin
								prefix_pos_d = 3'd0;
							end else if (lc == CH_LO_R) begin
								prefix_pos_d = 3'd1;
							end else if (ch == CH_HASH) begin
								form_d = FORM_HEX;
							end else begin
								failed_d = 1'b1;
							end
						end
						3'd1: begin
							if (lc == CH_LO_G) prefix_pos_d = 3'd2;
							else failed_d = 1'b1;
						end
						3'd2: begin
							if (lc == CH_LO_B) prefix_pos_d = 3'd3;
							else failed_d = 1'b1;
						end
						3'd3: begin
							if (ch == CH_PAREN) begin
								form_d     = FORM_RGB;
								acc_d      = 8'd0;
								comp_idx_d = 3'd0;
								in_run_d   = 1'b1;
							end else if (lc == CH_LO_A) begin
								prefix_pos_d = 3'd4;
							end else begin
								failed_d = 1'b1;
							end
						end
						default: begin
							if (ch == CH_PAREN) begin
								form_d     = FORM_RGBA;
								acc_d      = 8'd0;
								comp_idx_d = 3'd0;
								in_run_d   = 1'b1;
							end else begin
								failed_d = 1'b1;
							end
						end
					endcase
				end
				FORM_HEX: begin
					if (!is_digit && !is_hex_letter) begin
						failed_d = 1'b1;
					end else if (hex_cnt_q < HEX_LONG_A) begin
						nibbles_d = {nibbles_q[27:0], hex_val};
						hex_cnt_d = hex_cnt_q + 4'd1;
					end else begin
						hex_cnt_d = HEX_OVER;
					end
				end
				default: begin
					// Decimal components; a non-digit closes the running one.
					if (comp_idx_q < NUM_COMP) begin
						if (is_digit) begin
							acc_d    = (dec_sum > 12'd255) ? 8'd255 : dec_sum[7:0];
							in_run_d = 1'b1;
						end else begin
							if (in_run_q) begin
								store_d[comp_idx_q[1:0]] = acc_q;
								comp_idx_d               = comp_idx_q + 3'd1;
							end
							acc_d    = 8'd0;
							in_run_d = 1'b0;
						end
					end
				end
			endcase
		end
	end

	// Result from the state that includes the last character.
	always_comb begin
		color = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0, status: STATUS_OK};
		if (failed_d || form_d == FORM_UNDECIDED) begin
			color.status = STATUS_ERR;
		end else if (form_d == FORM_HEX) begin
			case (hex_cnt_d)
				HEX_SHORT: begin
					color.red   = {nibbles_d[11:8], nibbles_d[11:8]};
					color.green = {nibbles_d[7:4], nibbles_d[7:4]};
					color.blue  = {nibbles_d[3:0], nibbles_d[3:0]};
					color.alpha = 8'd255;
				end
				HEX_SHORT_A: begin
					color.red   = {nibbles_d[15:12], nibbles_d[15:12]};
					color.green = {nibbles_d[11:8], nibbles_d[11:8]};
					color.blue  = {nibbles_d[7:4], nibbles_d[7:4]};
					color.alpha = {nibbles_d[3:0], nibbles_d[3:0]};
				end
				HEX_LONG: begin
					color.red   = nibbles_d[23:16];
					color.green = nibbles_d[15:8];
					color.blue  = nibbles_d[7:0];
					color.alpha = 8'd255;
				end
				HEX_LONG_A: begin
					color.red   = nibbles_d[31:24];
					color.green = nibbles_d[23:16];
					color.blue  = nibbles_d[15:8];
					color.alpha = nibbles_d[7:0];
				end
				default: begin
					color.status = STATUS_ERR;
				end
			endcase
		end else begin
			color.red   = store_d[0];
			color.green = store_d[1];
			color.blue  = store_d[2];
			color.alpha = (form_d == FORM_RGB) ? 8'd255 : store_d[3];
		end
	end

	// State registers; the last character of a value returns them to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			form_q       <= FORM_UNDECIDED;
			prefix_pos_q <= 3'd0;
			hex_cnt_q    <= 4'd0;
			nibbles_q    <= 32'd0;
			acc_q        <= 8'd0;
			comp_idx_q   <= 3'd0;
			in_run_q     <= 1'b0;
			store_q      <= '{default: 8'd0};
			failed_q     <= 1'b0;
		end else if (step.valid) begin
			if (step.last_char) begin
				form_q       <= FORM_UNDECIDED;
				prefix_pos_q <= 3'd0;
				hex_cnt_q    <= 4'd0;
				nibbles_q    <= 32'd0;
				acc_q        <= 8'd0;
				comp_idx_q   <= 3'd0;
				in_run_q     <= 1'b0;
				store_q      <= '{default: 8'd0};
				failed_q     <= 1'b0;
			end else begin
				form_q       <= form_d;
				prefix_pos_q <= prefix_pos_d;
				hex_cnt_q    <= hex_cnt_d;
				nibbles_q    <= nibbles_d;
				acc_q        <= acc_d;
				comp_idx_q   <= comp_idx_d;
				in_run_q     <= in_run_d;
				store_q      <= store_d;
				failed_q     <= failed_d;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// Component count never passes the number of stored slots.
	a_comp_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		comp_idx_q <= NUM_COMP)
		else $error("component index out of range");

	// Hex digit count saturates at one past the longest form.
	a_hex_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		hex_cnt_q <= HEX_OVER)
		else $error("hex digit count out of range");

	// Hex digits are only counted in the hex form.
	a_hex_form: assert property (@(posedge clk) disable iff (!arst_n)
		hex_cnt_q != 4'd0 |-> form_q == FORM_HEX)
		else $error("hex digits counted outside hex form");

	// A finished value leaves the parser clean for the next one.
	a_clean_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step.valid && step.last_char |=> form_q == FORM_UNDECIDED && !failed_q
			&& prefix_pos_q == 3'd0)
		else $error("parser state not cleared after last character");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/css_color_value_parser_top.sv =====
// A result appears on the master side after the last character of a value has
// passed the input register, then the result register.
// Throughput: one character per cycle while no held result stalls the input register.
// Reset: arst_n clears the parser state and both valid flags at once.
`default_nettype none

module css_color_value_parser_top
	import ccvp_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] char_code
	input  wire         s_tlast,   // last_char
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
	output logic        m_tuser    // status
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       out_free;
	step_t      step;
	color_t     color;
	color_t     color_q;
	logic       m_valid_q;

	// The character register moves on whenever the result register can take a value.
	assign out_free = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || out_free;

	assign step = '{valid: valid_s1 && out_free, char_code: char_s1, last_char: last_s1};

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	ccvp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.color  (color)
	);

	// Result register, loaded by the last character of a value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step.valid && step.last_char) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.valid && step.last_char) begin
			color_q <= color;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {color_q.alpha, color_q.blue, color_q.green, color_q.red};
	assign m_tuser  = color_q.status;

`ifndef NO_ASSERTIONS
	// A held result is never overwritten before its transfer.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_tready |-> !step.valid)
		else $error("result register overwritten while stalled");

	// An error result carries zero color components.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && color_q.status == STATUS_ERR |-> m_tdata == 32'd0)
		else $error("error result with nonzero components");

	// A stalled character stays in the input register.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("stalled character lost");
`endif

endmodule

`default_nettype wire

// ===== sim/css_color_value_parser_top_tb.sv =====
`default_nettype none

module css_color_value_parser_top_tb;
	import ccvp_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int TARGET_CHARS = 1450;
	localparam int DRAIN_CYCLES = 6;

	// One character waiting to be sent; hold marks a value that starts only after all
	// earlier colors have come back.
	typedef struct packed {
		logic [7:0] code;
		logic       last;
		logic       hold;
	} char_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;

	char_item_t char_q[$];
	color_t     color_q[$];
	int         errors = 0;
	int         chars_queued = 0;
	bit         hold_next = 1'b0;

	// Parser state of the predictor.
	form_t      pk_form = FORM_UNDECIDED;
	logic [2:0] pk_prefix = '0;
	logic [3:0] pk_hex_count = '0;
	logic [31:0] pk_nibbles = '0;
	logic [7:0] pk_acc = '0;
	logic [2:0] pk_comp_idx = '0;
	logic       pk_in_run = 1'b0;
	logic [7:0] pk_comp [4];
	logic       pk_bad = 1'b0;

	// Sender pacing and receiver pattern.
	int burst_left = 0;
	int gap_left = 0;
	int rx_count = 0;
	int rx_mode = 0;
	int idle_cycles = 0;

	css_color_value_parser_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c >= CH_UP_A && c <= CH_UP_Z) begin
			return c + 8'd32;
		end
		return c;
	endfunction

	function automatic int hex_digit(input logic [7:0] c);
		logic [7:0] lc;
		lc = fold_case(c);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			return int'(c - CH_ZERO);
		end
		if (lc >= CH_LO_A && lc <= CH_LO_F) begin
			return int'(lc - CH_LO_A) + 10;
		end
		return -1;
	endfunction

	// Digit k of the hex value, counted from the first one received.
	function automatic logic [3:0] nibble_of(input int k);
		int shift;
		shift = 4 * ((int'(pk_hex_count) - 1 - k) & 7);
		return 4'((pk_nibbles >> shift) & 32'd15);
	endfunction

	task automatic clear_parser();
		pk_form = FORM_UNDECIDED;
		pk_prefix = '0;
		pk_hex_count = '0;
		pk_nibbles = '0;
		pk_acc = '0;
		pk_comp_idx = '0;
		pk_in_run = 1'b0;
		for (int i = 0; i < 4; i++) begin
			pk_comp[i] = '0;
		end
		pk_bad = 1'b0;
	endtask

	task automatic start_decimal(input form_t kind);
		pk_form = kind;
		pk_acc = '0;
		pk_comp_idx = '0;
		pk_in_run = 1'b1;
	endtask

	// Advances the predictor by one transferred character and queues the color it
	// yields on the last character of a value.
	task automatic parse_char(input logic [7:0] c, input logic lst);
		logic [7:0] lc;
		int hv;
		int acc;
		color_t res;
		lc = fold_case(c);
		if (!pk_bad) begin
			case (pk_form)
				FORM_UNDECIDED: begin
					case (pk_prefix)
						3'd0: begin
							if (c != CH_SPACE) begin
								if (lc == CH_LO_R) pk_prefix = 3'd1;
								else if (c == CH_HASH) pk_form = FORM_HEX;
								else pk_bad = 1'b1;
							end
						end
						3'd1: begin
							if (lc == CH_LO_G) pk_prefix = 3'd2;
							else pk_bad = 1'b1;
						end
						3'd2: begin
							if (lc == CH_LO_B) pk_prefix = 3'd3;
							else pk_bad = 1'b1;
						end
						3'd3: begin
							if (c == CH_PAREN) start_decimal(FORM_RGB);
							else if (lc == CH_LO_A) pk_prefix = 3'd4;
							else pk_bad = 1'b1;
						end
						default: begin
							if (c == CH_PAREN) start_decimal(FORM_RGBA);
							else pk_bad = 1'b1;
						end
					endcase
				end
				FORM_HEX: begin
					hv = hex_digit(c);
					if (hv < 0) begin
						pk_bad = 1'b1;
					end else if (pk_hex_count < HEX_LONG_A) begin
						pk_nibbles = {pk_nibbles[27:0], 4'(hv)};
						pk_hex_count = pk_hex_count + 4'd1;
					end else begin
						pk_hex_count = HEX_OVER;
					end
				end
				default: begin
					if (pk_comp_idx < NUM_COMP) begin
						if (c >= CH_ZERO && c <= CH_NINE) begin
							acc = int'(pk_acc) * 10 + int'(c - CH_ZERO);
							pk_acc = (acc > 255) ? 8'd255 : 8'(acc);
							pk_in_run = 1'b1;
						end else begin
							if (pk_in_run) begin
								pk_comp[pk_comp_idx[1:0]] = pk_acc;
								pk_comp_idx = pk_comp_idx + 3'd1;
							end
							pk_acc = '0;
							pk_in_run = 1'b0;
						end
					end
				end
			endcase
		end
		if (lst) begin
			res = '0;
			res.status = STATUS_OK;
			if (pk_bad || pk_form == FORM_UNDECIDED) begin
				res.status = STATUS_ERR;
			end else if (pk_form == FORM_HEX) begin
				if (pk_hex_count == HEX_SHORT || pk_hex_count == HEX_SHORT_A) begin
					res.red = nibble_of(0) * 8'd17;
					res.green = nibble_of(1) * 8'd17;
					res.blue = nibble_of(2) * 8'd17;
					res.alpha = (pk_hex_count == HEX_SHORT_A) ? nibble_of(3) * 8'd17 : 8'd255;
				end else if (pk_hex_count == HEX_LONG || pk_hex_count == HEX_LONG_A) begin
					res.red = {nibble_of(0), nibble_of(1)};
					res.green = {nibble_of(2), nibble_of(3)};
					res.blue = {nibble_of(4), nibble_of(5)};
					res.alpha = (pk_hex_count == HEX_LONG_A) ?
						{nibble_of(6), nibble_of(7)} : 8'd255;
				end else begin
					res.status = STATUS_ERR;
				end
			end else begin
				res.red = pk_comp[0];
				res.green = pk_comp[1];
				res.blue = pk_comp[2];
				res.alpha = (pk_form == FORM_RGB) ? 8'd255 : pk_comp[3];
			end
			color_q.push_back(res);
			clear_parser();
		end
	endtask

	// Stimulus building: characters are queued one by one and the value is closed by
	// flagging its final character.
	task automatic add_char(input logic [7:0] c);
		char_item_t item;
		item.code = c;
		item.last = 1'b0;
		item.hold = hold_next;
		hold_next = 1'b0;
		char_q.push_back(item);
		chars_queued++;
	endtask

	task automatic close_value();
		char_item_t item;
		item = char_q.pop_back();
		item.last = 1'b1;
		char_q.push_back(item);
	endtask

	task automatic add_text(input string s, input bit mix_case);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mix_case && c >= CH_LO_A && c <= (CH_UP_Z + 8'd32) && $urandom_range(0, 1) == 1)
				c = c - 8'd32;
			add_char(c);
		end
	endtask

	task automatic add_spaces(input int max_count);
		int n;
		n = $urandom_range(0, max_count);
		for (int i = 0; i < n; i++) begin
			add_char(CH_SPACE);
		end
	endtask

	task automatic add_hex_value();
		int len;
		int bad_at;
		int v;
		logic [7:0] c;
		add_spaces(2);
		add_char(CH_HASH);
		case ($urandom_range(0, 9))
			0, 1: len = 3;
			2, 3: len = 4;
			4, 5: len = 6;
			6, 7: len = 8;
			default: len = $urandom_range(0, 11);
		endcase
		bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : -1;
		for (int i = 0; i < len; i++) begin
			if (i == bad_at) begin
				add_char(8'($urandom_range(0, 255)));
			end
			v = $urandom_range(0, 15);
			c = (v < 10) ? CH_ZERO + 8'(v) : CH_LO_A + 8'(v - 10);
			if (v >= 10 && $urandom_range(0, 1) == 1) c = c - 8'd32;
			add_char(c);
		end
		if (bad_at == len) begin
			add_char(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic add_decimal_value();
		int ncomp;
		int n;
		string num;
		string pre;
		add_spaces(2);
		if ($urandom_range(0, 1) == 1) pre = "rgb(";
		else pre = "rgba(";
		add_text(pre, 1'b1);
		ncomp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : $urandom_range(3, 4);
		for (int k = 0; k < ncomp; k++) begin
			add_spaces(1);
			if ($urandom_range(0, 7) != 0) begin
				case ($urandom_range(0, 5))
					0: n = 0;
					1: n = 255;
					2: n = $urandom_range(256, 999);
					default: n = $urandom_range(0, 255);
				endcase
				if ($urandom_range(0, 7) == 0) add_char(CH_ZERO);
				num = $sformatf("%0d", n);
				add_text(num, 1'b0);
			end
			// The closing character may be left off the final component.
			if (k != ncomp - 1 || $urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 5))
					0, 1: add_char(8'h2c);
					2: add_char(CH_SPACE);
					3: add_char(8'h29);
					4: add_char(8'h25);
					default: add_char(8'($urandom_range(0, 255)));
				endcase
			end
		end
		if (ncomp == 0 && $urandom_range(0, 1) == 1) add_char(8'h29);
	endtask

	task automatic add_broken_value();
		string s;
		int k;
		s = "rgba(";
		add_spaces(1);
		k = $urandom_range(1, 4);
		for (int i = 0; i < k; i++) begin
			add_text(s.substr(i, i), 1'b1);
		end
		if ($urandom_range(0, 1) == 1) add_char(8'($urandom_range(0, 255)));
	endtask

	task automatic add_noise_value();
		int n;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			add_char(8'($urandom_range(0, 255)));
		end
	endtask

	// Sender: bursts of random length with random gaps, valid held until transfer.
	always @(posedge clk or negedge arst_n) begin : drive_chars
		logic       nv;
		logic [7:0] nd;
		logic       nl;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			nv = s_tvalid;
			nd = s_tdata;
			nl = s_tlast;
			if (s_tvalid && s_tready) begin
				parse_char(s_tdata, s_tlast);
				void'(char_q.pop_front());
				nv = 1'b0;
				if (burst_left != 0) burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			end
			if (!nv) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (char_q.size() != 0 &&
					!(char_q[0].hold && color_q.size() != 0)) begin
					if (burst_left == 0)
						burst_left = ($urandom_range(0, 7) == 0) ?
							$urandom_range(100, 300) : $urandom_range(1, 24);
					nv = 1'b1;
					nd = char_q[0].code;
					nl = char_q[0].last;
				end
			end
			s_tvalid <= nv;
			s_tdata <= nd;
			s_tlast <= nl;
		end
	end

	// Receiver: m_tready follows a stall pattern that rx_mode selects at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_count <= 0;
			rx_mode <= 0;
		end else begin
			rx_count <= rx_count + 1;
			if (rx_count % 128 == 127) rx_mode <= $urandom_range(0, 3);
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 1) == 1);
				2: m_tready <= (rx_count % 4 == 0);
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Monitor: each color transfer is compared with the oldest expected color.
	always @(posedge clk) begin : watch_colors
		color_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (color_q.size() == 0) begin
				$display("%0t: unexpected color, expected none, actual %h status %b",
					$time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = color_q.pop_front();
				check_field("red", want.red, m_tdata[7:0]);
				check_field("green", want.green, m_tdata[15:8]);
				check_field("blue", want.blue, m_tdata[23:16]);
				check_field("alpha", want.alpha, m_tdata[31:24]);
				check_field("status", 8'(want.status), 8'(m_tuser));
			end
		end
	end

	// Watchdog: too many cycles without any transfer ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("css_color_value_parser_top regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		clear_parser();

		// Directed values: short hex with mixed case, a space then an unknown
		// character, rgba with a saturated component and an unclosed digit run,
		// a bad hex length, only spaces, a lone unknown character, and a value
		// that stops inside the prefix.
		add_text("#F0a", 1'b0);
		close_value();
		add_text(" x", 1'b0);
		close_value();
		add_text("rGbA(300,7", 1'b0);
		close_value();
		add_text("#1", 1'b0);
		close_value();
		add_text("  ", 1'b0);
		close_value();
		add_text("(", 1'b0);
		close_value();
		add_text("rgb", 1'b0);
		close_value();

		// Random values, mostly well formed, with a full drain now and then.
		hold_next = 1'b1;
		while (chars_queued < TARGET_CHARS) begin
			if ($urandom_range(0, 15) == 0) hold_next = 1'b1;
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6: add_hex_value();
				7, 8, 9, 10, 11, 12, 13: add_decimal_value();
				14, 15: add_broken_value();
				16, 17: add_noise_value();
				default: begin
					add_spaces(2);
					add_char(CH_SPACE);
				end
			endcase
			close_value();
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (char_q.size() != 0 || color_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("css_color_value_parser_top regression: pass");
		end else begin
			$display("css_color_value_parser_top regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
